// ===== rtl/trirast_pkg.sv =====
// ----------------------------------------------------------------------------
// trirast_pkg
// Shared types and constants of the triangle coverage rasterizer: field
// widths, opcodes, register indexes and the job record passed front to back.
// ----------------------------------------------------------------------------
package trirast_pkg;

    // image and mask geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // fixed-point formats: vertices are Q12.4, edge values are exact products
    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 4;
    localparam int HALF_PIXEL = 8;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 2;
    localparam int BOX_W      = 14;

    // configuration
    localparam int CFG_W = 7;

    // stream widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result status codes
    localparam logic STATUS_DONE       = 1'b0;
    localparam logic STATUS_DEGENERATE = 1'b1;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [BOX_W-1:0]   box_t;
    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [MAX_WIDTH-1:0]      row_bits_t;

    // one classified item, ready for the row walker
    typedef struct packed {
        opcode_t         opcode;
        logic            degenerate;
        logic            box_empty;
        col_t            lx;
        col_t            hx;
        row_t            ly;
        row_t            hy;
        row_t            row_index;
        edge_t [2:0]     base;
        diff_t [2:0]     dx;
        diff_t [2:0]     dy;
    } job_t;

endpackage

// ===== rtl/trirast_front.sv =====
// ----------------------------------------------------------------------------
// trirast_front
// Accepts one item, works out edge deltas, the clamped bounding box, the
// zero-area test and the edge values at the first pixel row, then queues it.
// ----------------------------------------------------------------------------
module trirast_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trirast_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [trirast_pkg::CFG_W-1:0]   image_width,
    input  logic [trirast_pkg::CFG_W-1:0]   image_height,
    output logic                            push,
    output trirast_pkg::job_t               push_job,
    input  logic                            full
);

    typedef enum logic [3:0] {
        FS_IDLE = 4'b0001,
        FS_SPAN = 4'b0010,
        FS_MUL  = 4'b0100,
        FS_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;

    // captured item
    trirast_pkg::opcode_t opcode_reg;
    trirast_pkg::coord_t  vx_reg [3];
    trirast_pkg::coord_t  vy_reg [3];
    trirast_pkg::row_t    row_index_reg;

    // setup results
    trirast_pkg::diff_t   dx_reg [3];
    trirast_pkg::diff_t   dy_reg [3];
    trirast_pkg::col_t    lx_reg, hx_reg;
    trirast_pkg::row_t    ly_reg, hy_reg;
    logic                 empty_reg;
    trirast_pkg::prod_t   pa_reg, pb_reg;
    trirast_pkg::prod_t   t1_reg [3];
    trirast_pkg::prod_t   t2_reg [3];

    // edge k runs from vertex a to vertex b
    trirast_pkg::coord_t  a_x [3], a_y [3], b_x [3], b_y [3];

    trirast_pkg::coord_t  min_x, max_x, min_y, max_y;
    logic signed [trirast_pkg::DIFF_W-1:0] max_x_up, max_y_up;
    trirast_pkg::box_t    fl_x, cl_x, fl_y, cl_y;
    trirast_pkg::box_t    lo_x, hi_x, lo_y, hi_y, lim_x, lim_y;
    logic [trirast_pkg::CFG_W-1:0] w_eff, h_eff;
    trirast_pkg::diff_t   ox [3], oy [3];

    assign s_tready = (state_reg == FS_IDLE);
    assign push     = (state_reg == FS_PUSH);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE: if (s_tvalid) state_next = FS_SPAN;
            FS_SPAN: state_next = FS_MUL;
            FS_MUL:  state_next = FS_PUSH;
            FS_PUSH: if (!full) state_next = FS_IDLE;
            default: state_next = FS_IDLE;
        endcase
    end

    // edge endpoints
    always_comb begin
        a_x[0] = vx_reg[1]; a_y[0] = vy_reg[1]; b_x[0] = vx_reg[2]; b_y[0] = vy_reg[2];
        a_x[1] = vx_reg[2]; a_y[1] = vy_reg[2]; b_x[1] = vx_reg[0]; b_y[1] = vy_reg[0];
        a_x[2] = vx_reg[0]; a_y[2] = vy_reg[0]; b_x[2] = vx_reg[1]; b_y[2] = vy_reg[1];
    end

    // bounding box: floor of minimum, ceiling of maximum, clamped to image
    always_comb begin
        min_x = vx_reg[0];
        max_x = vx_reg[0];
        min_y = vy_reg[0];
        max_y = vy_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (vx_reg[i] < min_x) min_x = vx_reg[i];
            if (vx_reg[i] > max_x) max_x = vx_reg[i];
            if (vy_reg[i] < min_y) min_y = vy_reg[i];
            if (vy_reg[i] > max_y) max_y = vy_reg[i];
        end
        max_x_up = trirast_pkg::diff_t'(max_x) +
                   trirast_pkg::diff_t'((1 << trirast_pkg::FRAC_W) - 1);
        max_y_up = trirast_pkg::diff_t'(max_y) +
                   trirast_pkg::diff_t'((1 << trirast_pkg::FRAC_W) - 1);
        fl_x = trirast_pkg::box_t'(min_x >>> trirast_pkg::FRAC_W);
        fl_y = trirast_pkg::box_t'(min_y >>> trirast_pkg::FRAC_W);
        cl_x = trirast_pkg::box_t'(max_x_up >>> trirast_pkg::FRAC_W);
        cl_y = trirast_pkg::box_t'(max_y_up >>> trirast_pkg::FRAC_W);

        w_eff = (image_width > trirast_pkg::CFG_W'(trirast_pkg::MAX_WIDTH)) ?
                trirast_pkg::CFG_W'(trirast_pkg::MAX_WIDTH) : image_width;
        h_eff = (image_height > trirast_pkg::CFG_W'(trirast_pkg::MAX_HEIGHT)) ?
                trirast_pkg::CFG_W'(trirast_pkg::MAX_HEIGHT) : image_height;
        lim_x = trirast_pkg::box_t'({1'b0, w_eff}) - trirast_pkg::box_t'(1);
        lim_y = trirast_pkg::box_t'({1'b0, h_eff}) - trirast_pkg::box_t'(1);

        lo_x = (fl_x < trirast_pkg::box_t'(0)) ? trirast_pkg::box_t'(0) : fl_x;
        lo_y = (fl_y < trirast_pkg::box_t'(0)) ? trirast_pkg::box_t'(0) : fl_y;
        hi_x = (cl_x > lim_x) ? lim_x : cl_x;
        hi_y = (cl_y > lim_y) ? lim_y : cl_y;
    end

    // offsets of the first pixel center from each edge start
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ox[k] = trirast_pkg::diff_t'(trirast_pkg::HALF_PIXEL) -
                    trirast_pkg::diff_t'(a_x[k]);
            oy[k] = trirast_pkg::diff_t'({ly_reg,
                        trirast_pkg::FRAC_W'(trirast_pkg::HALF_PIXEL)}) -
                    trirast_pkg::diff_t'(a_y[k]);
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == FS_IDLE && s_tvalid) begin
            // tdata: opcode, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, row_index
            opcode_reg    <= trirast_pkg::opcode_t'(s_tdata[1:0]);
            vx_reg[0]     <= $signed(s_tdata[17:2]);
            vy_reg[0]     <= $signed(s_tdata[33:18]);
            vx_reg[1]     <= $signed(s_tdata[49:34]);
            vy_reg[1]     <= $signed(s_tdata[65:50]);
            vx_reg[2]     <= $signed(s_tdata[81:66]);
            vy_reg[2]     <= $signed(s_tdata[97:82]);
            row_index_reg <= s_tdata[103:98];
        end
        if (state_reg == FS_SPAN) begin
            for (int k = 0; k < 3; k++) begin
                dx_reg[k] <= trirast_pkg::diff_t'(b_x[k]) - trirast_pkg::diff_t'(a_x[k]);
                dy_reg[k] <= trirast_pkg::diff_t'(b_y[k]) - trirast_pkg::diff_t'(a_y[k]);
            end
            lx_reg    <= trirast_pkg::COL_W'(lo_x);
            hx_reg    <= trirast_pkg::COL_W'(hi_x);
            ly_reg    <= trirast_pkg::ROW_W'(lo_y);
            hy_reg    <= trirast_pkg::ROW_W'(hi_y);
            empty_reg <= (lo_x > hi_x) || (lo_y > hi_y);
        end
        if (state_reg == FS_MUL) begin
            // doubled area terms and edge values at (x=0, y=ly)
            pa_reg <= dy_reg[1] * dx_reg[2];
            pb_reg <= dx_reg[1] * dy_reg[2];
            for (int k = 0; k < 3; k++) begin
                t1_reg[k] <= ox[k] * dy_reg[k];
                t2_reg[k] <= oy[k] * dx_reg[k];
            end
        end
    end

    // queued job
    always_comb begin
        push_job.opcode     = opcode_reg;
        push_job.degenerate = (pa_reg == pb_reg);
        push_job.box_empty  = empty_reg;
        push_job.lx         = lx_reg;
        push_job.hx         = hx_reg;
        push_job.ly         = ly_reg;
        push_job.hy         = hy_reg;
        push_job.row_index  = row_index_reg;
        for (int k = 0; k < 3; k++) begin
            push_job.base[k] = trirast_pkg::edge_t'(t1_reg[k]) -
                               trirast_pkg::edge_t'(t2_reg[k]);
            push_job.dx[k]   = dx_reg[k];
            push_job.dy[k]   = dy_reg[k];
        end
    end

endmodule

// ===== rtl/trirast_fifo.sv =====
// ----------------------------------------------------------------------------
// trirast_fifo
// Short job queue that lets the setup front and the row walker stall
// independently of each other.
// ----------------------------------------------------------------------------
module trirast_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  trirast_pkg::job_t push_job,
    output logic              full,
    input  logic              pop,
    output trirast_pkg::job_t head_job,
    output logic              not_empty
);

    trirast_pkg::job_t entry_reg [trirast_pkg::QUEUE_DEPTH];
    logic [trirast_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [trirast_pkg::QCNT_W-1:0] count_reg;

    logic do_push, do_pop;

    assign full      = (count_reg == trirast_pkg::QCNT_W'(trirast_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = entry_reg[rd_ptr_reg];

    function automatic logic [trirast_pkg::QPTR_W-1:0] bump(
        input logic [trirast_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == trirast_pkg::QPTR_W'(trirast_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/trirast_back.sv =====
// ----------------------------------------------------------------------------
// trirast_back
// Row walker: holds the coverage mask memory, evaluates all columns of one
// row per cycle, merges them into the stored row, serves reads and clears,
// and drives the result register.
// ----------------------------------------------------------------------------
module trirast_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               job_valid,
    input  trirast_pkg::job_t                  job,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [trirast_pkg::OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        BS_IDLE = 4'b0001,
        BS_ROW  = 4'b0010,
        BS_READ = 4'b0100,
        BS_DONE = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;

    trirast_pkg::job_t      job_reg;
    trirast_pkg::row_t      y_reg;
    trirast_pkg::edge_t     rowbase_reg [3];
    trirast_pkg::edge_t     dx16 [3];
    trirast_pkg::edge_t     dy16 [3];
    trirast_pkg::row_bits_t lane_bits;

    // coverage mask, one word per row; rows not yet written read as zero
    trirast_pkg::row_bits_t mask_mem [trirast_pkg::MAX_HEIGHT];
    logic [trirast_pkg::MAX_HEIGHT-1:0] row_valid_reg;
    trirast_pkg::row_t      rd_addr;
    trirast_pkg::row_bits_t rdata_reg;
    logic                   rd_valid_reg;
    trirast_pkg::row_bits_t old_row;

    // pending read-modify-write
    logic                   wpend_reg;
    trirast_pkg::row_t      waddr_reg;
    trirast_pkg::row_bits_t wbits_reg;

    // result staging and output register
    trirast_pkg::row_bits_t res_row_reg;
    logic                   res_status_reg;
    logic                   m_tvalid_reg;
    trirast_pkg::row_bits_t m_row_reg;
    logic                   m_status_reg;
    logic                   load_out;
    logic                   clear_mask;

    assign pop        = (state_reg == BS_IDLE) && job_valid;
    assign load_out   = (state_reg == BS_DONE) && (!m_tvalid_reg || m_tready);
    assign clear_mask = pop && (job.opcode == trirast_pkg::OP_CLEAR);
    assign rd_addr    = (state_reg == BS_IDLE) ? job.row_index : y_reg;
    assign old_row    = rd_valid_reg ? rdata_reg : '0;

    assign m_tvalid = m_tvalid_reg;
    // tdata: row_bits, status
    assign m_tdata  = trirast_pkg::OUT_DATA_W'({m_status_reg, m_row_reg});

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (job_valid) begin
                    unique case (job.opcode)
                        trirast_pkg::OP_DRAW: begin
                            if (job.degenerate || job.box_empty) begin
                                state_next = BS_DONE;
                            end else begin
                                state_next = BS_ROW;
                            end
                        end
                        trirast_pkg::OP_READ: state_next = BS_READ;
                        default:              state_next = BS_DONE;
                    endcase
                end
            end
            BS_ROW:  if (y_reg == job_reg.hy) state_next = BS_DONE;
            BS_READ: state_next = BS_DONE;
            BS_DONE: if (load_out) state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_IDLE;
            wpend_reg     <= 1'b0;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wpend_reg <= (state_reg == BS_ROW);
            if (clear_mask) begin
                row_valid_reg <= '0;
            end else if (wpend_reg) begin
                row_valid_reg[waddr_reg] <= 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // per-edge steps: one column adds 16*dy, one row subtracts 16*dx
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx16[k] = trirast_pkg::edge_t'(job_reg.dx[k]) <<< trirast_pkg::FRAC_W;
            dy16[k] = trirast_pkg::edge_t'(job_reg.dy[k]) <<< trirast_pkg::FRAC_W;
        end
    end

    // coverage of every column of the current row
    always_comb begin : lane_eval
        logic               pos, neg;
        trirast_pkg::edge_t e;
        for (int x = 0; x < trirast_pkg::MAX_WIDTH; x++) begin
            pos = 1'b1;
            neg = 1'b1;
            for (int k = 0; k < 3; k++) begin
                e   = rowbase_reg[k] + dy16[k] * trirast_pkg::edge_t'(x);
                pos = pos & (e >= trirast_pkg::edge_t'(0));
                neg = neg & (e <= trirast_pkg::edge_t'(0));
            end
            lane_bits[x] = (pos | neg) &&
                           (trirast_pkg::COL_W'(x) >= job_reg.lx) &&
                           (trirast_pkg::COL_W'(x) <= job_reg.hx);
        end
    end

    // mask memory: one read and one write port
    always_ff @(posedge aclk) begin
        if (wpend_reg) mask_mem[waddr_reg] <= wbits_reg | old_row;
        rdata_reg    <= mask_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
    end

    // walker and result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg        <= job;
            y_reg          <= job.ly;
            res_row_reg    <= '0;
            res_status_reg <= (job.opcode == trirast_pkg::OP_DRAW && job.degenerate) ?
                              trirast_pkg::STATUS_DEGENERATE : trirast_pkg::STATUS_DONE;
            for (int k = 0; k < 3; k++) rowbase_reg[k] <= job.base[k];
        end
        if (state_reg == BS_ROW) begin
            waddr_reg <= y_reg;
            wbits_reg <= lane_bits;
            y_reg     <= y_reg + 1'b1;
            for (int k = 0; k < 3; k++) rowbase_reg[k] <= rowbase_reg[k] - dx16[k];
        end
        if (state_reg == BS_READ) begin
            res_row_reg <= old_row;
        end
        if (load_out) begin
            m_row_reg    <= res_row_reg;
            m_status_reg <= res_status_reg;
        end
    end

endmodule

// ===== rtl/triangle_coverage_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer
// Edge-function triangle rasterizer into a one-bit 64x64 coverage mask.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. The setup front registers an item's
// bounding box, then its area test and edge values with one layer of 17x17
// multipliers, then hands it through a two-entry queue to the row walker, so
// setup of the next item overlaps the walk of the current one. In the walker
// a draw walks the rows of its clamped bounding box; the single read and
// write port of the mask memory merges one full row per cycle. A zero-area
// or off-image draw, a clear or an unused opcode goes straight to the result,
// and a row read first passes its read state. The mask needs no clearing
// pass: per-row valid bits make reset and a clear take effect at once.
// Configuration writes must only happen while the block is idle.
// ----------------------------------------------------------------------------
module triangle_coverage_rasterizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: opcode[1:0], v0_x[17:2], v0_y[33:18], v1_x[49:34], v1_y[65:50],
    //        v2_x[81:66], v2_y[97:82], row_index[103:98]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [trirast_pkg::IN_DATA_W-1:0]  s_tdata,
    // tdata: row_bits[63:0], status[64], zero fill [71:65]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [trirast_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [trirast_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [trirast_pkg::CFG_W-1:0] image_width_reg, image_height_reg;

    logic              push, full, pop, job_valid;
    trirast_pkg::job_t push_job, head_job;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= trirast_pkg::CFG_W'(trirast_pkg::MAX_WIDTH);
            image_height_reg <= trirast_pkg::CFG_W'(trirast_pkg::MAX_HEIGHT);
        end else if (cfg_we) begin
            unique case (trirast_pkg::cfg_reg_t'(cfg_addr))
                trirast_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                trirast_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // setup front
    trirast_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .push         (push),
        .push_job     (push_job),
        .full         (full)
    );

    // job queue
    trirast_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (job_valid)
    );

    // row walker and mask memory
    trirast_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/trirast_checker.sv =====
// ----------------------------------------------------------------------------
// trirast_checker
// Port-level checks of the rasterizer: reset, result hold, result contents
// and no result without an outstanding item.
// ----------------------------------------------------------------------------
module trirast_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [trirast_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [3:0] outstanding_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // items taken but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else if (in_xfer && !out_xfer) begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a skipped triangle carries no row bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[trirast_pkg::MAX_WIDTH] |->
            m_tdata[trirast_pkg::MAX_WIDTH-1:0] == '0)
        else $error("degenerate status with row bits");

    // every result answers an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> outstanding_reg != '0)
        else $error("result without an outstanding item");

endmodule

bind triangle_coverage_rasterizer trirast_checker u_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of triangle_coverage_rasterizer. An in-bench coverage
// mask model predicts one result per transfer (draw status, read row bits,
// clear), and a checker compares every result transfer in order. Directed
// cases come first, then register extremes, then random traffic under four
// idling modes with image sizes changed between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STUCK_LIMIT = 2000;
    localparam int         SETTLE_CYC  = 80;

    // one input transfer, laid out as s_tdata (first field in the low bits)
    typedef struct packed {
        logic [5:0]          row_index;
        trirast_pkg::coord_t v2_y;
        trirast_pkg::coord_t v2_x;
        trirast_pkg::coord_t v1_y;
        trirast_pkg::coord_t v1_x;
        trirast_pkg::coord_t v0_y;
        trirast_pkg::coord_t v0_x;
        logic [1:0]          opcode;
    } raster_cmd_t;

    // one result transfer, laid out as m_tdata[64:0]
    typedef struct packed {
        logic                   status;
        trirast_pkg::row_bits_t row_bits;
    } raster_result_t;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [trirast_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [trirast_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                               cfg_we    = 1'b0;
    logic                               cfg_addr  = 1'b0;
    logic [trirast_pkg::CFG_W-1:0]      cfg_wdata = '0;

    // mask model and its settings
    trirast_pkg::row_bits_t        mask_rows [trirast_pkg::MAX_HEIGHT];
    logic [trirast_pkg::CFG_W-1:0] image_width;
    logic [trirast_pkg::CFG_W-1:0] image_height;
    raster_result_t                predicted_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int result_count   = 0;
    int stuck_cycles   = 0;
    int n_draws = 0, n_degenerate = 0, n_reads = 0, n_lit_reads = 0;
    int n_clears = 0, n_unused = 0, n_size_changes = 0;

    triangle_coverage_rasterizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // mask model
    // ------------------------------------------------------------------
    function automatic longint edge_value(input longint ax, ay, bx, by, px, py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    // returns 1 when the triangle has zero area and is skipped
    function automatic logic draw_triangle(input raster_cmd_t c);
        longint x0, y0, x1, y1, x2, y2;
        longint w, h, lx, hx, ly, hy, px, py, e0, e1, e2;
        x0 = longint'(c.v0_x); y0 = longint'(c.v0_y);
        x1 = longint'(c.v1_x); y1 = longint'(c.v1_y);
        x2 = longint'(c.v2_x); y2 = longint'(c.v2_y);
        w = (image_width > trirast_pkg::MAX_WIDTH) ? longint'(trirast_pkg::MAX_WIDTH) :
                                                     longint'(image_width);
        h = (image_height > trirast_pkg::MAX_HEIGHT) ? longint'(trirast_pkg::MAX_HEIGHT) :
                                                       longint'(image_height);
        if (edge_value(x0, y0, x1, y1, x2, y2) == 0)
            return 1'b1;
        // bounding box in whole pixels: floor of min, ceiling of max
        lx = x0; if (x1 < lx) lx = x1; if (x2 < lx) lx = x2;
        hx = x0; if (x1 > hx) hx = x1; if (x2 > hx) hx = x2;
        ly = y0; if (y1 < ly) ly = y1; if (y2 < ly) ly = y2;
        hy = y0; if (y1 > hy) hy = y1; if (y2 > hy) hy = y2;
        lx = lx >>> trirast_pkg::FRAC_W;
        ly = ly >>> trirast_pkg::FRAC_W;
        hx = (hx + 15) >>> trirast_pkg::FRAC_W;
        hy = (hy + 15) >>> trirast_pkg::FRAC_W;
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > w - 1) hx = w - 1;
        if (hy > h - 1) hy = h - 1;
        // pixel centers sit at x*16+8; zero counts as either sign
        for (longint y = ly; y <= hy; y++) begin
            py = y * 16 + trirast_pkg::HALF_PIXEL;
            for (longint x = lx; x <= hx; x++) begin
                px = x * 16 + trirast_pkg::HALF_PIXEL;
                e0 = edge_value(x1, y1, x2, y2, px, py);
                e1 = edge_value(x2, y2, x0, y0, px, py);
                e2 = edge_value(x0, y0, x1, y1, px, py);
                if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0))
                    mask_rows[trirast_pkg::ROW_W'(y)][trirast_pkg::COL_W'(x)] = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic raster_result_t rasterize_item(input raster_cmd_t c);
        raster_result_t r;
        r = '0;
        case (c.opcode)
            trirast_pkg::OP_DRAW: begin
                r.status = draw_triangle(c) ? trirast_pkg::STATUS_DEGENERATE :
                                              trirast_pkg::STATUS_DONE;
                n_draws++;
                if (r.status == trirast_pkg::STATUS_DEGENERATE) n_degenerate++;
            end
            trirast_pkg::OP_READ: begin
                r.row_bits = mask_rows[c.row_index];
                n_reads++;
                if (r.row_bits != '0) n_lit_reads++;
            end
            trirast_pkg::OP_CLEAR: begin
                foreach (mask_rows[i]) mask_rows[i] = '0;
                n_clears++;
            end
            default: n_unused++;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker and stall generator
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        raster_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[64:0];
            if (predicted_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result transfer: row_bits %h status %b",
                             got.row_bits, got.status);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                if (got.row_bits !== want.row_bits || got.status !== want.status) begin
                    if (mismatch_count < 10)
                        $display({"result %0d: expected row_bits %h status %b, ",
                                  "got row_bits %h status %b"},
                                 result_count, want.row_bits, want.status,
                                 got.row_bits, got.status);
                    mismatch_count++;
                end
            end
            result_count++;
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, predicted_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic raster_cmd_t random_fill();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return raster_cmd_t'(r[trirast_pkg::IN_DATA_W-1:0]);
    endfunction

    // valid stays high between back-to-back transfers
    task automatic send_item(input raster_cmd_t c);
        raster_result_t expected;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        expected = rasterize_item(c);
        predicted_results = {predicted_results, expected};
    endtask

    task automatic send_draw(input int x0, y0, x1, y1, x2, y2);
        raster_cmd_t c;
        c = random_fill();
        c.opcode = trirast_pkg::OP_DRAW;
        c.v0_x = trirast_pkg::coord_t'(x0); c.v0_y = trirast_pkg::coord_t'(y0);
        c.v1_x = trirast_pkg::coord_t'(x1); c.v1_y = trirast_pkg::coord_t'(y1);
        c.v2_x = trirast_pkg::coord_t'(x2); c.v2_y = trirast_pkg::coord_t'(y2);
        send_item(c);
    endtask

    task automatic send_read(input int r);
        raster_cmd_t c;
        c = random_fill();
        c.opcode    = trirast_pkg::OP_READ;
        c.row_index = r[5:0];
        send_item(c);
    endtask

    task automatic send_plain(input logic [1:0] op);
        raster_cmd_t c;
        c = random_fill();
        c.opcode = op;
        send_item(c);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic set_image_size(input logic [trirast_pkg::CFG_W-1:0] w,
                                  input logic [trirast_pkg::CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_addr  <= trirast_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr  <= trirast_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        image_width  = w;
        image_height = h;
        n_size_changes++;
    endtask

    function automatic raster_cmd_t random_draw();
        raster_cmd_t c;
        int pick, cx, cy, span, dx, dy, k;
        c = random_fill();
        c.opcode = trirast_pkg::OP_DRAW;
        pick = $urandom_range(99);
        if (pick < 50) begin
            // compact triangle near or on the image
            cx = rand_span(-64, 1100);
            cy = rand_span(-64, 1100);
            span = rand_span(8, 200);
            c.v0_x = trirast_pkg::coord_t'(cx + rand_span(-span, span));
            c.v0_y = trirast_pkg::coord_t'(cy + rand_span(-span, span));
            c.v1_x = trirast_pkg::coord_t'(cx + rand_span(-span, span));
            c.v1_y = trirast_pkg::coord_t'(cy + rand_span(-span, span));
            c.v2_x = trirast_pkg::coord_t'(cx + rand_span(-span, span));
            c.v2_y = trirast_pkg::coord_t'(cy + rand_span(-span, span));
        end else if (pick < 70) begin
            // large triangle reaching past the borders
            c.v0_x = trirast_pkg::coord_t'(rand_span(-320, 1344));
            c.v0_y = trirast_pkg::coord_t'(rand_span(-320, 1344));
            c.v1_x = trirast_pkg::coord_t'(rand_span(-320, 1344));
            c.v1_y = trirast_pkg::coord_t'(rand_span(-320, 1344));
            c.v2_x = trirast_pkg::coord_t'(rand_span(-320, 1344));
            c.v2_y = trirast_pkg::coord_t'(rand_span(-320, 1344));
        end else if (pick < 80) begin
            // zero area: collinear or repeated vertices
            dx = rand_span(-100, 100);
            dy = rand_span(-100, 100);
            k  = rand_span(-3, 3);
            cx = rand_span(-200, 1200);
            cy = rand_span(-200, 1200);
            c.v0_x = trirast_pkg::coord_t'(cx);
            c.v0_y = trirast_pkg::coord_t'(cy);
            c.v1_x = trirast_pkg::coord_t'(cx + dx);
            c.v1_y = trirast_pkg::coord_t'(cy + dy);
            c.v2_x = trirast_pkg::coord_t'(cx + k * dx);
            c.v2_y = trirast_pkg::coord_t'(cy + k * dy);
        end else if (pick < 90) begin
            // vertices on pixel centers, so edges pass through centers
            c.v0_x = trirast_pkg::coord_t'(rand_span(-2, 66) * 16 + trirast_pkg::HALF_PIXEL);
            c.v0_y = trirast_pkg::coord_t'(rand_span(-2, 66) * 16 + trirast_pkg::HALF_PIXEL);
            c.v1_x = trirast_pkg::coord_t'(rand_span(-2, 66) * 16 + trirast_pkg::HALF_PIXEL);
            c.v1_y = trirast_pkg::coord_t'(rand_span(-2, 66) * 16 + trirast_pkg::HALF_PIXEL);
            c.v2_x = trirast_pkg::coord_t'(rand_span(-2, 66) * 16 + trirast_pkg::HALF_PIXEL);
            c.v2_y = trirast_pkg::coord_t'(rand_span(-2, 66) * 16 + trirast_pkg::HALF_PIXEL);
            if ($urandom_range(1)) begin
                c.v1_y = c.v0_y;
                c.v2_x = c.v0_x;
            end
        end
        // otherwise keep the full 16-bit random vertices
        return c;
    endfunction

    function automatic raster_cmd_t random_item();
        raster_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return random_draw();
        c = random_fill();
        if (pick < 90)      c.opcode = trirast_pkg::OP_READ;
        else if (pick < 94) c.opcode = trirast_pkg::OP_CLEAR;
        else                c.opcode = OP_UNUSED;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        send_read(0);
        // covers the whole image; the later extreme-corner draw winds the other way
        send_draw(-16, -16, 2100, -16, -16, 2100);
        send_read(0);
        send_read(63);
        send_plain(trirast_pkg::OP_CLEAR);
        send_read(63);
        send_draw(-32768, -32768, -32768, 32767, 32767, -32768);
        send_read(31);
        send_plain(trirast_pkg::OP_CLEAR);
        // small triangles of opposite winding
        send_draw(16, 16, 160, 16, 16, 160);
        send_draw(400, 400, 400, 560, 560, 400);
        send_read(3);
        send_read(27);
        // zero area: all equal, two equal, collinear, extreme corner
        send_draw(100, 100, 100, 100, 100, 100);
        send_draw(40, 40, 40, 40, 300, 90);
        send_draw(0, 0, 100, 100, 200, 200);
        send_draw(32767, 32767, 32767, 32767, 32767, 32767);
        // boxes entirely off the image
        send_draw(-500, -500, -300, -500, -500, -300);
        send_draw(2000, 100, 2300, 100, 2000, 400);
        // edges through pixel centers
        send_draw(8, 808, 168, 808, 8, 968);
        send_read(50);
        send_read(60);
        send_plain(OP_UNUSED);
        send_read(63);
        wait_results_drained();
    endtask

    task automatic test_register_extremes();
        int sizes [8][2] = '{'{0, 0}, '{1, 1}, '{127, 127}, '{2, 64}, '{64, 2},
                             '{0, 64}, '{1, 127}, '{64, 64}};
        foreach (sizes[i]) begin
            wait_results_drained();
            set_image_size(trirast_pkg::CFG_W'(sizes[i][0]),
                           trirast_pkg::CFG_W'(sizes[i][1]));
            // bits left from larger widths stay unless cleared
            if (i % 2 == 1) send_plain(trirast_pkg::OP_CLEAR);
            send_draw(-16, -16, 2100, -16, -16, 2100);
            send_read(0);
            send_read(1);
            send_read(63);
            repeat (4) send_item(random_item());
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int per_size);
        logic [trirast_pkg::CFG_W-1:0] w, h;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            wait_results_drained();
            case ($urandom_range(3))
                0: begin
                    w = trirast_pkg::CFG_W'(64);
                    h = trirast_pkg::CFG_W'(64);
                end
                1: begin
                    w = trirast_pkg::CFG_W'(rand_span(2, 8));
                    h = trirast_pkg::CFG_W'(rand_span(2, 8));
                end
                2: begin
                    w = trirast_pkg::CFG_W'(rand_span(2, 64));
                    h = trirast_pkg::CFG_W'(rand_span(2, 64));
                end
                default: begin
                    w = trirast_pkg::CFG_W'(127);
                    h = trirast_pkg::CFG_W'(rand_span(2, 127));
                end
            endcase
            set_image_size(w, h);
            repeat (per_size) send_item(random_item());
        end
        wait_results_drained();
    endtask

    initial begin
        foreach (mask_rows[i]) mask_rows[i] = '0;
        image_width  = trirast_pkg::CFG_W'(trirast_pkg::MAX_WIDTH);
        image_height = trirast_pkg::CFG_W'(trirast_pkg::MAX_HEIGHT);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_register_extremes();
        test_random_traffic(0, 0, 45);
        test_random_traffic(82, 0, 45);
        test_random_traffic(0, 82, 45);
        test_random_traffic(32, 32, 45);

        wait_results_drained();
        repeat (SETTLE_CYC) @(posedge aclk);

        $display("covered %0d draws (%0d zero area), %0d row reads (%0d non-empty)",
                 n_draws, n_degenerate, n_reads, n_lit_reads);
        $display("plus %0d clears, %0d unused opcodes, %0d image size changes, %0d results",
                 n_clears, n_unused, n_size_changes, result_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/trirast_pkg.sv
rtl/trirast_front.sv
rtl/trirast_fifo.sv
rtl/trirast_back.sv
rtl/triangle_coverage_rasterizer.sv
rtl/trirast_checker.sv
dv/tb.sv
